### hw/rtl/bpl_pkg.sv
// shared types and constants for the byte pattern locator
package bpl_pkg;

  localparam int unsigned MaxPatternDef    = 16;
  localparam int unsigned TextPositionsDef = 65536;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PatBytes  = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned StartW    = 16;
  localparam int unsigned EndW      = 17;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow  = 2'd0,
    CfgPatHigh = 2'd1,
    CfgPatLen  = 2'd2
  } cfg_reg_e;

  // input beat
  typedef struct packed {
    logic [ByteW-1:0]  text_byte;
    logic              first_byte;
    logic              last_byte;
    logic [StartW-1:0] start_offset;
  } in_t;

  // result beat
  typedef struct packed {
    logic            found;
    logic [EndW-1:0] match_end;
  } out_t;

  // control broadcast to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### hw/rtl/byte_pattern_locator_top.sv
// top level of the byte pattern locator: window cells, match tracking, result register
//
// Usage: text bytes enter on the in channel one beat per byte; first_byte marks
// position zero and samples start_offset, last_byte marks the final byte. After
// the last byte one result beat leaves on the out channel with found and the
// index just past the first match (the start offset for an empty pattern).
// Pattern bytes and length are written on the cfg port while no text is in
// flight; the registers take effect the cycle after the write.
// Throughput is one byte per cycle while in_stall_o is low: each byte shifts the
// row of window cells and all cells compare against the aligned pattern in that
// same cycle. The result beat leaves the output register in the cycle after the
// last byte is accepted. While a result waits under out_stall_i, in_stall_o is high;
// a result taken in the same cycle frees the register for the next one.
// Reset clears the window, the position, the match state, the pattern registers
// and the output register.
module byte_pattern_locator_top #(
  parameter int unsigned MaxPattern    = bpl_pkg::MaxPatternDef,
  parameter int unsigned TextPositions = bpl_pkg::TextPositionsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bpl_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bpl_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [bpl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpl_pkg::CfgDataW-1:0] cfg_data_i
);
  import bpl_pkg::*;

  localparam int unsigned PosW = $clog2(TextPositions + 1);
  localparam int unsigned CmpW = EndW + 1;

  logic [MaxPattern-1:0][ByteW-1:0] aligned;
  logic [MaxPattern-1:0]            use_b;
  logic [LenW-1:0]                  len;
  logic [MaxPattern-1:0][ByteW-1:0] cell_in, cell_out;
  logic [MaxPattern-1:0]            hits;
  cell_ctrl_t                       ctrl;

  logic              accept, taken, window_hit, match_now;
  logic [PosW-1:0]   pos_q, pos_d, pos_eff;
  logic [StartW-1:0] start_q, start_d;
  logic              seen_q, seen_d, seen_eff;
  logic [EndW-1:0]   mend_q, mend_d;
  logic [CmpW-1:0]   end_ext, need_ext;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  bpl_cfg #(
    .MaxPattern(MaxPattern)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .aligned_o (aligned),
    .use_o     (use_b),
    .len_o     (len)
  );

  // handshake: stall only while a result is held back
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // position and match state as seen after the first-byte clear
  assign pos_eff  = in_data_i.first_byte ? '0 : pos_q;
  assign seen_eff = in_data_i.first_byte ? 1'b0 : seen_q;
  assign start_d  = in_data_i.first_byte ? in_data_i.start_offset : start_q;
  assign taken    = pos_eff < PosW'(TextPositions);

  assign ctrl.shift = accept && taken;
  assign ctrl.clear = in_data_i.first_byte;

  // row of window cells, newest byte in cell zero
  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_in[j] = in_data_i.text_byte;
    end else begin : g_link
      assign cell_in[j] = cell_out[j-1];
    end
    bpl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_i    (cell_in[j]),
      .pat_byte_i(aligned[j]),
      .use_i     (use_b[j]),
      .byte_o    (cell_out[j]),
      .hit_o     (hits[j])
    );
  end

  assign window_hit = &hits;

  // candidate ends at pos+1 and must start at or after the saved start
  assign end_ext  = CmpW'(pos_eff) + CmpW'(1);
  assign need_ext = CmpW'(len) + CmpW'(start_d);
  assign match_now = taken && !seen_eff && (len != '0) && (end_ext >= need_ext)
                     && window_hit;

  // next state of position and match tracking
  always_comb begin
    pos_d  = pos_q;
    seen_d = seen_q;
    mend_d = mend_q;
    if (accept) begin
      pos_d  = taken ? PosW'(end_ext) : pos_eff;
      seen_d = seen_eff || match_now;
      if (in_data_i.first_byte) begin
        mend_d = '0;
      end
      if (match_now) begin
        mend_d = EndW'(end_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      seen_q  <= 1'b0;
      mend_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
      mend_q <= mend_d;
      if (accept) begin
        start_q <= start_d;
      end
    end
  end

  // result beat for the last byte
  always_comb begin
    if (len == '0) begin
      out_d.found     = 1'b1;
      out_d.match_end = EndW'(start_d);
    end else if (seen_d) begin
      out_d.found     = 1'b1;
      out_d.match_end = mend_d;
    end else begin
      out_d.found     = 1'b0;
      out_d.match_end = '0;
    end
  end

  // output register
  always_comb begin
    if (accept && in_data_i.last_byte) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (accept && in_data_i.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/bpl_cell.sv
// one window cell: holds one recent byte and checks its incoming byte against its pattern byte
module bpl_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpl_pkg::cell_ctrl_t       ctrl_i,
  input  logic [bpl_pkg::ByteW-1:0] byte_i,
  input  logic [bpl_pkg::ByteW-1:0] pat_byte_i,
  input  logic                      use_i,
  output logic [bpl_pkg::ByteW-1:0] byte_o,
  output logic                      hit_o
);
  import bpl_pkg::*;

  logic [ByteW-1:0] byte_q, byte_d;

  // shift in the neighbor's byte
  always_comb begin
    byte_d = ctrl_i.shift ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare the byte arriving this beat; unused cells always agree
  assign hit_o = !use_i || (byte_i == pat_byte_i);

  // a new text starts with an empty window downstream
  assign byte_o = ctrl_i.clear ? '0 : byte_q;

endmodule

### hw/rtl/bpl_cfg.sv
// configuration registers and pattern alignment to the window cells
module bpl_cfg #(
  parameter int unsigned MaxPattern = bpl_pkg::MaxPatternDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpl_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [MaxPattern-1:0][bpl_pkg::ByteW-1:0] aligned_o,
  output logic [MaxPattern-1:0]        use_o,
  output logic [bpl_pkg::LenW-1:0]     len_o
);
  import bpl_pkg::*;

  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [LenW-1:0]     pat_len_q;
  logic [PatBytes-1:0][ByteW-1:0] pat;
  logic [LenW-1:0]     len_u;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgPatLow:  pat_low_q  <= cfg_data_i;
        CfgPatHigh: pat_high_q <= cfg_data_i;
        CfgPatLen:  pat_len_q  <= cfg_data_i[LenW-1:0];
        default:    ;
      endcase
    end
  end

  assign pat = {pat_high_q, pat_low_q};

  // clamp the length to the window size
  assign len_u = (pat_len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : pat_len_q;
  assign len_o = len_u;

  // cell j sees the pattern byte at len-1-j
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      if (LenW'(j) < len_u) begin
        use_o[j]     = 1'b1;
        aligned_o[j] = pat[4'(len_u - LenW'(j) - LenW'(1))];
      end else begin
        use_o[j]     = 1'b0;
        aligned_o[j] = '0;
      end
    end
  end

endmodule
